// ===== rtl/sacl_pkg.sv =====
// Shared types, constants and register codes for the set-associative cache lookup.
package sacl_pkg;

   localparam int ADDR_W       = 32;
   localparam int TAG_W        = 31;
   localparam int STAMP_W      = 32;
   localparam int COUNT_W      = 32;
   localparam int WAY_ID_W     = 3;
   localparam int WAY_CNT_W    = 4;
   localparam int OFFSET_W     = 4;
   localparam int INDEX_W      = 4;
   localparam int WAYS_LOG2_W  = 2;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 4;

   localparam int DEF_MAX_SETS = 256;
   localparam int DEF_MAX_WAYS = 8;

   localparam logic [OFFSET_W-1:0]    OFFSET_RST    = 4'd4;
   localparam logic [INDEX_W-1:0]     INDEX_RST     = 4'd6;
   localparam logic [WAYS_LOG2_W-1:0] WAYS_LOG2_RST = 2'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET_BITS = 2'd0,
      CSR_INDEX_BITS  = 2'd1,
      CSR_WAYS_LOG2   = 2'd2
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   // One way of a set as held in the line memory.
   typedef struct packed {
      logic               valid;
      logic [TAG_W-1:0]   tag;
      logic [STAMP_W-1:0] stamp;
   } line_type;

   // Outcome of the way selection for one lookup.
   typedef struct packed {
      logic                hit;
      logic [WAY_ID_W-1:0] way;
   } sel_type;

endpackage

// ===== rtl/sacl_if.sv =====
// Valid/ready channel interfaces for the request and response beats.
interface sacl_req_if;
   import sacl_pkg::*;

   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] address;

   modport source (output valid, output address, input ready);
   modport sink   (input valid, input address, output ready);
endinterface

interface sacl_rsp_if;
   import sacl_pkg::*;

   logic                valid;
   logic                ready;
   logic                hit;
   logic [WAY_ID_W-1:0] way_used;
   logic [COUNT_W-1:0]  access_total;
   logic [COUNT_W-1:0]  hit_total;

   modport source (output valid, output hit, output way_used, output access_total,
                   output hit_total, input ready);
   modport sink   (input valid, input hit, input way_used, input access_total,
                   input hit_total, output ready);
endinterface

// ===== rtl/sacl_way_select.sv =====
// Way selection for one set: tag match, first free way, or oldest stamp.
module sacl_way_select #(
   parameter int NWAYS = sacl_pkg::DEF_MAX_WAYS
) (
   input  sacl_pkg::line_type [NWAYS-1:0]       row,
   input  logic [sacl_pkg::TAG_W-1:0]           tag,
   input  logic [sacl_pkg::WAY_CNT_W-1:0]       way_count,
   output sacl_pkg::sel_type                    sel
);
   import sacl_pkg::*;

   logic [NWAYS-1:0] in_use;
   logic [NWAYS-1:0] match;
   logic [NWAYS-1:0] free;
   logic [NWAYS-1:0] cand;
   logic [NWAYS-1:0] oldest;

   always_comb begin
      for (int i = 0; i < NWAYS; i++) begin
         in_use[i] = WAY_CNT_W'(i) < way_count;
         match[i]  = in_use[i] && row[i].valid && (row[i].tag == tag);
         free[i]   = in_use[i] && !row[i].valid;
         cand[i]   = in_use[i] && row[i].valid && (row[i].tag != tag);
      end
   end

   // All pairwise stamp compares side by side; ties go to the lower way.
   always_comb begin
      for (int i = 0; i < NWAYS; i++) begin
         oldest[i] = cand[i];
         for (int j = 0; j < NWAYS; j++) begin
            if (j < i) begin
               if (cand[j] && !(row[i].stamp < row[j].stamp)) oldest[i] = 1'b0;
            end else if (j > i) begin
               if (cand[j] && !(row[i].stamp <= row[j].stamp)) oldest[i] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      sel.hit = |match;
      sel.way = '0;
      if (|match) begin
         for (int i = NWAYS - 1; i >= 0; i--) begin
            if (match[i]) sel.way = WAY_ID_W'(i);
         end
      end else if (|free) begin
         for (int i = NWAYS - 1; i >= 0; i--) begin
            if (free[i]) sel.way = WAY_ID_W'(i);
         end
      end else begin
         for (int i = NWAYS - 1; i >= 0; i--) begin
            if (oldest[i]) sel.way = WAY_ID_W'(i);
         end
      end
   end

endmodule

// ===== rtl/set_assoc_cache_lru_lookup.sv =====
// Top level of the set-associative cache lookup with LRU replacement.
//
// Request channel (req_ch): one beat carries a 32-bit byte address. Response
// channel (rsp_ch): one beat per request with the hit flag, the way that hit or
// was filled/replaced, and saturating access and hit totals.
// csr_*: write-only register port (offset bits, index bits, log2 ways); write
// only while no request is in flight.
//
// At accept (IDLE) the set's row is read from the line memory into a register;
// in LOOKUP all ways are compared, the row is written back and the response
// register is loaded, which raises rsp_ch.valid. The line memory takes one read
// and one write-back per request; the next request waits for the write-back.
//
// Reset: counters, configuration registers and state return to defaults, then
// a clearing pass zeroes every row of the line memory; req_ch.ready stays low
// during the pass (csr writes are taken).
// Receiver stall: a finished response waits in its register; the next request
// is still accepted and read, and its write-back holds off until the response
// register frees up.
module set_assoc_cache_lru_lookup #(
   parameter int MAX_SETS = sacl_pkg::DEF_MAX_SETS,
   parameter int MAX_WAYS = sacl_pkg::DEF_MAX_WAYS
) (
   input  logic                             clock,
   input  logic                             reset,
   sacl_req_if.sink                         req_ch,
   sacl_rsp_if.source                       rsp_ch,
   input  logic                             csr_we,
   input  logic [sacl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sacl_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import sacl_pkg::*;

   // Widest set index usable with MAX_SETS rows (floor of log2).
   localparam int IDX_MAX = $clog2(MAX_SETS + 1) - 1;
   localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;

   typedef line_type [MAX_WAYS-1:0] row_type;

   // Configuration registers
   logic [OFFSET_W-1:0]    offset_bits_ff, offset_bits_in;
   logic [INDEX_W-1:0]     index_bits_ff,  index_bits_in;
   logic [WAYS_LOG2_W-1:0] ways_log2_ff,   ways_log2_in;

   // Control
   state_type       state_ff, state_in;
   logic [SET_W-1:0] clr_idx_ff, clr_idx_in;
   logic            req_fire;
   logic            lookup_done;
   logic            clr_last;

   // Lookup context
   logic [TAG_W-1:0] tag_ff;
   logic [SET_W-1:0] set_ff;
   row_type          rd_row_ff;

   // Counters
   logic [COUNT_W-1:0] acc_cnt_ff, acc_cnt_in;
   logic [COUNT_W-1:0] hit_cnt_ff, hit_cnt_in;
   logic [COUNT_W-1:0] acc_next;
   logic [COUNT_W-1:0] hit_next;

   // Response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff;
   logic [WAY_ID_W-1:0] rsp_way_ff;
   logic [COUNT_W-1:0]  rsp_acc_ff;
   logic [COUNT_W-1:0]  rsp_hits_ff;

   // Address split
   logic [OFFSET_W-1:0]  eff_ob;
   logic [INDEX_W-1:0]   eff_ib;
   logic [WAY_CNT_W-1:0] eff_ways;
   logic [WAY_CNT_W-1:0] raw_ways;
   logic [ADDR_W-1:0]    addr_sh;
   logic [ADDR_W-1:0]    set_full;
   logic [ADDR_W-1:0]    tag_full;
   logic [SET_W-1:0]     rd_set;

   // Line memory, one row per set
   row_type          line_mem [MAX_SETS];
   logic             mem_we;
   logic [SET_W-1:0] mem_waddr;
   row_type          mem_wdata;
   row_type          upd_row;

   sel_type sel;

   //--------------------------------------------------------------------------
   // Configuration
   //--------------------------------------------------------------------------
   always_comb begin
      offset_bits_in = offset_bits_ff;
      index_bits_in  = index_bits_ff;
      ways_log2_in   = ways_log2_ff;
      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_OFFSET_BITS: offset_bits_in = csr_wdata[OFFSET_W-1:0];
            CSR_INDEX_BITS:  index_bits_in  = csr_wdata[INDEX_W-1:0];
            CSR_WAYS_LOG2:   ways_log2_in   = csr_wdata[WAYS_LOG2_W-1:0];
            default: ;  // unknown index: write dropped
         endcase
      end
   end

   // Effective geometry: offset of zero acts as one, index and ways clamp.
   always_comb begin
      eff_ob   = (offset_bits_ff == '0) ? OFFSET_W'(1) : offset_bits_ff;
      eff_ib   = (index_bits_ff > INDEX_W'(IDX_MAX)) ? INDEX_W'(IDX_MAX) : index_bits_ff;
      raw_ways = WAY_CNT_W'(1) << ways_log2_ff;
      eff_ways = (raw_ways > WAY_CNT_W'(MAX_WAYS)) ? WAY_CNT_W'(MAX_WAYS) : raw_ways;
   end

   always_comb begin
      addr_sh  = req_ch.address >> eff_ob;
      set_full = addr_sh & ~({ADDR_W{1'b1}} << eff_ib);
      rd_set   = set_full[SET_W-1:0];
      tag_full = req_ch.address >> ({1'b0, eff_ob} + {1'b0, eff_ib});
   end

   //--------------------------------------------------------------------------
   // Sequencer
   //--------------------------------------------------------------------------
   assign clr_last = (clr_idx_ff == SET_W'(MAX_SETS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (clr_last) state_in = ST_IDLE;
         ST_IDLE:   if (req_ch.valid) state_in = ST_LOOKUP;
         ST_LOOKUP: if (!rsp_valid_ff || rsp_ch.ready) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req_ch.ready = 1'b0;
      lookup_done  = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = set_ff;
      mem_wdata    = upd_row;
      clr_idx_in   = clr_idx_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_idx_ff;
            mem_wdata  = '0;
            clr_idx_in = clr_idx_ff + SET_W'(1);
         end
         ST_IDLE: begin
            req_ch.ready = 1'b1;
         end
         ST_LOOKUP: begin
            lookup_done = !rsp_valid_ff || rsp_ch.ready;
            mem_we      = lookup_done;
         end
         default: ;
      endcase
   end

   assign req_fire = req_ch.valid && req_ch.ready;

   //--------------------------------------------------------------------------
   // Way selection and row update
   //--------------------------------------------------------------------------
   sacl_way_select #(
      .NWAYS (MAX_WAYS)
   ) u_way_select (
      .row       (rd_row_ff),
      .tag       (tag_ff),
      .way_count (eff_ways),
      .sel       (sel)
   );

   assign acc_next = (acc_cnt_ff == '1) ? acc_cnt_ff : acc_cnt_ff + COUNT_W'(1);
   assign hit_next = (sel.hit && hit_cnt_ff != '1) ? hit_cnt_ff + COUNT_W'(1) : hit_cnt_ff;

   always_comb begin
      upd_row = rd_row_ff;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (WAY_ID_W'(i) == sel.way) begin
            upd_row[i].stamp = acc_next;
            if (!sel.hit) begin
               upd_row[i].valid = 1'b1;
               upd_row[i].tag   = tag_ff;
            end
         end
      end
   end

   always_comb begin
      acc_cnt_in = lookup_done ? acc_next : acc_cnt_ff;
      hit_cnt_in = lookup_done ? hit_next : hit_cnt_ff;
   end

   assign rsp_valid_in = lookup_done ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   //--------------------------------------------------------------------------
   // Line memory: reads only at accept (IDLE), writes only in CLEAR/LOOKUP,
   // so a read never meets a write-back of the same row.
   //--------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) line_mem[mem_waddr] <= mem_wdata;
      if (req_fire) rd_row_ff <= line_mem[rd_set];
   end

   //--------------------------------------------------------------------------
   // Registers
   //--------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_idx_ff     <= '0;
         offset_bits_ff <= OFFSET_RST;
         index_bits_ff  <= INDEX_RST;
         ways_log2_ff   <= WAYS_LOG2_RST;
         acc_cnt_ff     <= '0;
         hit_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_idx_ff     <= clr_idx_in;
         offset_bits_ff <= offset_bits_in;
         index_bits_ff  <= index_bits_in;
         ways_log2_ff   <= ways_log2_in;
         acc_cnt_ff     <= acc_cnt_in;
         hit_cnt_ff     <= hit_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         tag_ff <= tag_full[TAG_W-1:0];
         set_ff <= rd_set;
      end
      if (lookup_done) begin
         rsp_hit_ff  <= sel.hit;
         rsp_way_ff  <= sel.way;
         rsp_acc_ff  <= acc_next;
         rsp_hits_ff <= hit_next;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.hit          = rsp_hit_ff;
   assign rsp_ch.way_used     = rsp_way_ff;
   assign rsp_ch.access_total = rsp_acc_ff;
   assign rsp_ch.hit_total    = rsp_hits_ff;

   //--------------------------------------------------------------------------
   // Assertions
   //--------------------------------------------------------------------------
   a_hits_le_access: assert property (@(posedge clock) disable iff (reset)
      hit_cnt_ff <= acc_cnt_ff)
      else $error("hit count ran ahead of access count");

   a_done_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      lookup_done |=> rsp_valid_ff && rsp_acc_ff == acc_cnt_ff && rsp_hits_ff == hit_cnt_ff)
      else $error("finished lookup did not load the response register");

   a_acc_only_on_done: assert property (@(posedge clock) disable iff (reset)
      !lookup_done |=> $stable(acc_cnt_ff))
      else $error("access count moved without a finished lookup");

   a_hit_counts: assert property (@(posedge clock) disable iff (reset)
      (lookup_done && sel.hit && hit_cnt_ff != '1) |=> hit_cnt_ff == $past(hit_cnt_ff) + 1)
      else $error("hit not counted");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR || state_ff == ST_LOOKUP) |-> !mem_we || !req_fire)
      else $error("memory read and write-back collided");

endmodule
